@@ rtl/blk3_pkg.sv @@
// Shared types and constants of the BLAKE3 hash engine.
`timescale 1ns / 1ps
package blk3_pkg;

  localparam logic [3:0] F_BEGIN  = 4'h1;
  localparam logic [3:0] F_END    = 4'h2;
  localparam logic [3:0] F_PARENT = 4'h4;
  localparam logic [3:0] F_ROOT   = 4'h8;

  localparam logic [255:0] IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [6:0] BLOCK_BYTES = 7'd64;
  localparam logic [6:0] MAX_WORDS   = 7'd64;

  // One queued block: a full block to compress, or the closing block of a message.
  typedef struct packed {
    logic         is_final;
    logic [6:0]   len;
    logic [511:0] block;
  } blk3_cmd_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // Quarter-round mixing of four state words; returns {d, c, b, a}.
  function automatic logic [127:0] gmix(input logic [31:0] a_in, input logic [31:0] b_in,
                                        input logic [31:0] c_in, input logic [31:0] d_in,
                                        input logic [31:0] x, input logic [31:0] y);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    a = a_in + b_in + x;
    d = rotr(d_in ^ a, 16);
    c = c_in + d;
    b = rotr(b_in ^ c, 12);
    a = a + b + y;
    d = rotr(d ^ a, 8);
    c = c + d;
    b = rotr(b ^ c, 7);
    gmix = {d, c, b, a};
  endfunction

endpackage

@@ rtl/blk3_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module blk3_ram #(
  parameter int WIDTH = 256,
  parameter int DEPTH = 54,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/blk3_compress.sv @@
// BLAKE3 compression unit: one half round (four mixes) per cycle.
`timescale 1ns / 1ps
module blk3_compress (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [255:0] cv_in,
  input  logic [511:0] m_in,
  input  logic [63:0]  ctr,
  input  logic [6:0]   len,
  input  logic [3:0]   flags,
  output logic         done,
  output logic [511:0] res
);

  logic [31:0] v [16];
  logic [31:0] m [16];
  logic [31:0] cv [8];
  logic [31:0] vcol [16];
  logic [31:0] vdiag [16];
  logic [3:0]  step;
  logic        busy;

  genvar g;
  for (g = 0; g < 4; g++) begin : g_mix
    localparam int BD = 4 + ((g + 1) % 4);
    localparam int CD = 8 + ((g + 2) % 4);
    localparam int DD = 12 + ((g + 3) % 4);
    logic [127:0] oc;
    logic [127:0] od;
    assign oc = blk3_pkg::gmix(v[g], v[4+g], v[8+g], v[12+g], m[2*g], m[2*g+1]);
    assign od = blk3_pkg::gmix(v[g], v[BD], v[CD], v[DD], m[8+2*g], m[9+2*g]);
    assign vcol[g]     = oc[31:0];
    assign vcol[4+g]   = oc[63:32];
    assign vcol[8+g]   = oc[95:64];
    assign vcol[12+g]  = oc[127:96];
    assign vdiag[g]    = od[31:0];
    assign vdiag[BD]   = od[63:32];
    assign vdiag[CD]   = od[95:64];
    assign vdiag[DD]   = od[127:96];
  end

  for (g = 0; g < 8; g++) begin : g_res
    assign res[32*g +: 32]     = v[g] ^ v[g+8];
    assign res[256+32*g +: 32] = v[g+8] ^ cv[g];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 4'd0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        step <= 4'd0;
      end else if (busy) begin
        step <= step + 4'd1;
        if (step == 4'd13) begin
          busy <= 1'b0;
        end
      end
      done <= !start && busy && (step == 4'd13);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < 8; i++) begin
        v[i]   <= cv_in[32*i +: 32];
        cv[i]  <= cv_in[32*i +: 32];
      end
      for (int i = 0; i < 4; i++) begin
        v[i+8] <= blk3_pkg::IV[32*i +: 32];
      end
      v[12] <= ctr[31:0];
      v[13] <= ctr[63:32];
      v[14] <= {25'd0, len};
      v[15] <= {28'd0, flags};
      for (int i = 0; i < 16; i++) begin
        m[i] <= m_in[32*i +: 32];
      end
    end else if (busy) begin
      if (!step[0]) begin
        v <= vcol;
      end else begin
        v <= vdiag;
        // Message schedule permutation after each full round.
        m[0]  <= m[2];  m[1]  <= m[6];  m[2]  <= m[3];  m[3]  <= m[10];
        m[4]  <= m[7];  m[5]  <= m[0];  m[6]  <= m[4];  m[7]  <= m[13];
        m[8]  <= m[1];  m[9]  <= m[11]; m[10] <= m[12]; m[11] <= m[5];
        m[12] <= m[9];  m[13] <= m[14]; m[14] <= m[15]; m[15] <= m[8];
      end
    end
  end

endmodule

@@ rtl/blk3_queue.sv @@
// Two-entry queue of block commands between the byte packer and the sequencer.
`timescale 1ns / 1ps
module blk3_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  blk3_pkg::blk3_cmd_t push_cmd,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output blk3_pkg::blk3_cmd_t head
);

  blk3_pkg::blk3_cmd_t mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ rtl/blk3_front.sv @@
// Byte packer: gathers input beats into 64-byte blocks and queues them.
`timescale 1ns / 1ps
module blk3_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [63:0]         data,
  input  logic [3:0]          byte_count,
  input  logic                last,
  input  logic                q_full,
  output logic                push,
  output blk3_pkg::blk3_cmd_t push_cmd
);

  logic [511:0] buffer;
  logic [6:0]   fill;
  logic         pend;
  logic [3:0]   cnt;
  logic [7:0]   total;
  logic [7:0]   over;
  logic [511:0] merged;
  logic [63:0]  ovb;
  logic         ovf;
  logic         accept;

  assign cnt    = (byte_count > 4'd8) ? 4'd8 : byte_count;
  assign total  = {1'b0, fill} + {4'd0, cnt};
  assign over   = total - {1'b0, blk3_pkg::BLOCK_BYTES};
  assign ovf    = total > {1'b0, blk3_pkg::BLOCK_BYTES};
  assign item_stall = pend || q_full;
  assign accept = item_valid && !item_stall;

  always_comb begin
    logic [2:0] j;
    for (int i = 0; i < 64; i++) begin
      j = 3'(8'(i) - {1'b0, fill});
      if ((8'(i) >= {1'b0, fill}) && (8'(i) < total)) begin
        merged[8*i +: 8] = data[8*j +: 8];
      end else begin
        merged[8*i +: 8] = buffer[8*i +: 8];
      end
    end
    // Bytes that spill past a full block start the next one.
    for (int i = 0; i < 8; i++) begin
      j = 3'(8'(i) + {1'b0, blk3_pkg::BLOCK_BYTES} - {1'b0, fill});
      ovb[8*i +: 8] = (8'(i) < over) ? data[8*j +: 8] : 8'd0;
    end
  end

  always_comb begin
    push     = 1'b0;
    push_cmd = '{is_final: 1'b0, len: blk3_pkg::BLOCK_BYTES, block: merged};
    if (pend) begin
      push     = !q_full;
      push_cmd = '{is_final: 1'b1, len: fill, block: buffer};
    end else if (accept) begin
      if (ovf) begin
        push = 1'b1;
      end else if (last) begin
        push     = 1'b1;
        push_cmd = '{is_final: 1'b1, len: total[6:0], block: merged};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer <= '0;
      fill   <= 7'd0;
      pend   <= 1'b0;
    end else if (pend) begin
      if (!q_full) begin
        buffer <= '0;
        fill   <= 7'd0;
        pend   <= 1'b0;
      end
    end else if (accept) begin
      if (ovf) begin
        buffer <= {448'd0, ovb};
        fill   <= over[6:0];
        pend   <= last;
      end else if (last) begin
        buffer <= '0;
        fill   <= 7'd0;
      end else begin
        buffer <= merged;
        fill   <= total[6:0];
      end
    end
  end

endmodule

@@ rtl/blk3_back.sv @@
// Sequencer: chunk chaining, subtree merges, root output and digest beats.
`timescale 1ns / 1ps
module blk3_back #(
  parameter int STACK_DEPTH = 54
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [6:0]          output_words,
  input  logic                q_valid,
  input  blk3_pkg::blk3_cmd_t q_head,
  output logic                pop,
  output logic                digest_valid,
  input  logic                digest_stall,
  output logic [63:0]         digest_word,
  output logic                last_word
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_BWAIT = 4'd1;
  localparam logic [3:0] S_MCHK  = 4'd2;
  localparam logic [3:0] S_MRD   = 4'd3;
  localparam logic [3:0] S_MWAIT = 4'd4;
  localparam logic [3:0] S_TRD   = 4'd5;
  localparam logic [3:0] S_OGEN  = 4'd6;
  localparam logic [3:0] S_OWAIT = 4'd7;
  localparam logic [3:0] S_OEMIT = 4'd8;

  logic [3:0]   state;
  logic [255:0] cv;
  logic [63:0]  chunk_ctr;
  logic [3:0]   block_index;
  logic [255:0] cur;
  logic [63:0]  rem;
  logic [6:0]   level;
  logic         rd_zero;
  logic [255:0] root_chain;
  logic [511:0] root_block;
  logic [6:0]   root_len;
  logic [3:0]   root_flags;
  logic [511:0] obuf;
  logic [6:0]   k;
  logic [6:0]   n;
  logic [3:0]   blk_flags;

  logic         c_start;
  logic [255:0] c_cv;
  logic [511:0] c_m;
  logic [63:0]  c_ctr;
  logic [6:0]   c_len;
  logic [3:0]   c_flags;
  logic         c_done;
  logic [511:0] c_res;

  logic            s_we;
  logic [AW-1:0]   s_addr;
  logic [255:0]    s_rdata;
  logic [255:0]    sdata;
  logic            in_stack;
  logic            emit;

  assign n = (output_words == 7'd0) ? 7'd1 :
             (output_words > blk3_pkg::MAX_WORDS) ? blk3_pkg::MAX_WORDS : output_words;
  assign blk_flags = ((block_index == 4'd0) ? blk3_pkg::F_BEGIN : 4'd0) |
                     ((q_head.is_final || block_index == 4'd15) ? blk3_pkg::F_END : 4'd0);
  assign in_stack = level < 7'(STACK_DEPTH);
  assign s_addr   = level[AW-1:0];
  assign sdata    = rd_zero ? 256'd0 : s_rdata;
  assign emit     = (state == S_OEMIT) && (!digest_valid || !digest_stall);

  blk3_ram #(.WIDTH(256), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_addr),
    .wdata (cur),
    .raddr (s_addr),
    .rdata (s_rdata)
  );

  blk3_compress u_comp (
    .clk   (clk),
    .rst   (rst),
    .start (c_start),
    .cv_in (c_cv),
    .m_in  (c_m),
    .ctr   (c_ctr),
    .len   (c_len),
    .flags (c_flags),
    .done  (c_done),
    .res   (c_res)
  );

  always_comb begin
    c_start = 1'b0;
    c_cv    = cv;
    c_m     = q_head.block;
    c_ctr   = chunk_ctr;
    c_len   = q_head.is_final ? q_head.len : blk3_pkg::BLOCK_BYTES;
    c_flags = blk_flags;
    s_we    = 1'b0;
    pop     = 1'b0;
    unique case (state)
      S_IDLE: begin
        c_start = q_valid && !(q_head.is_final && chunk_ctr == 64'd0);
      end
      S_BWAIT: begin
        pop = c_done && !q_head.is_final && block_index != 4'd15;
      end
      S_MCHK: begin
        if (!q_head.is_final && !rem[0]) begin
          s_we = in_stack;
          pop  = 1'b1;
        end
      end
      S_MRD: begin
        c_start = 1'b1;
        c_cv    = blk3_pkg::IV;
        c_m     = {cur, sdata};
        c_ctr   = 64'd0;
        c_len   = blk3_pkg::BLOCK_BYTES;
        c_flags = blk3_pkg::F_PARENT;
      end
      S_OGEN: begin
        c_start = 1'b1;
        c_cv    = root_chain;
        c_m     = root_block;
        c_ctr   = {61'd0, k[5:3]};
        c_len   = root_len;
        c_flags = root_flags;
      end
      S_OEMIT: begin
        pop = emit && (k == n - 7'd1);
      end
      S_MWAIT, S_TRD, S_OWAIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cv           <= blk3_pkg::IV;
      chunk_ctr    <= 64'd0;
      block_index  <= 4'd0;
      digest_valid <= 1'b0;
    end else begin
      if (digest_valid && !digest_stall && !emit) begin
        digest_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_head.is_final && chunk_ctr == 64'd0) begin
              root_chain <= cv;
              root_block <= q_head.block;
              root_len   <= q_head.len;
              root_flags <= blk_flags | blk3_pkg::F_ROOT;
              k          <= 7'd0;
              state      <= S_OGEN;
            end else begin
              state <= S_BWAIT;
            end
          end
        end
        S_BWAIT: begin
          if (c_done) begin
            if (q_head.is_final || block_index == 4'd15) begin
              cur   <= c_res[255:0];
              rem   <= chunk_ctr;
              level <= 7'd0;
              state <= S_MCHK;
              if (!q_head.is_final) begin
                cv          <= blk3_pkg::IV;
                block_index <= 4'd0;
              end
            end else begin
              cv          <= c_res[255:0];
              block_index <= block_index + 4'd1;
              state       <= S_IDLE;
            end
          end
        end
        S_MCHK: begin
          rd_zero <= !in_stack;
          if (q_head.is_final) begin
            // The highest set bit of the chunk count is the root's left child.
            if (rem[63:1] == 63'd0) begin
              state <= S_TRD;
            end else if (rem[0]) begin
              state <= S_MRD;
            end else begin
              level <= level + 7'd1;
              rem   <= rem >> 1;
            end
          end else if (rem[0]) begin
            state <= S_MRD;
          end else begin
            chunk_ctr <= chunk_ctr + 64'd1;
            state     <= S_IDLE;
          end
        end
        S_MRD: begin
          state <= S_MWAIT;
        end
        S_MWAIT: begin
          if (c_done) begin
            cur   <= c_res[255:0];
            level <= level + 7'd1;
            rem   <= rem >> 1;
            state <= S_MCHK;
          end
        end
        S_TRD: begin
          root_chain <= blk3_pkg::IV;
          root_block <= {cur, sdata};
          root_len   <= blk3_pkg::BLOCK_BYTES;
          root_flags <= blk3_pkg::F_PARENT | blk3_pkg::F_ROOT;
          k          <= 7'd0;
          state      <= S_OGEN;
        end
        S_OGEN: begin
          state <= S_OWAIT;
        end
        S_OWAIT: begin
          if (c_done) begin
            obuf  <= c_res;
            state <= S_OEMIT;
          end
        end
        S_OEMIT: begin
          if (emit) begin
            digest_valid <= 1'b1;
            digest_word  <= obuf[64*k[2:0] +: 64];
            last_word    <= (k == n - 7'd1);
            k            <= k + 7'd1;
            if (k == n - 7'd1) begin
              cv          <= blk3_pkg::IV;
              chunk_ctr   <= 64'd0;
              block_index <= 4'd0;
              state       <= S_IDLE;
            end else if (k[2:0] == 3'd7) begin
              state <= S_OGEN;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/blake3_hash_engine.sv @@
// The 64-byte blocks share the single half-round compression unit; each chunk end
// adds one subtree merge per trailing one bit of the chunk count. After the last
// beat: final block, merges, then the digest words in groups of eight per root
// output block. Synchronous reset clears the message state; output_words resets to 4.
`timescale 1ns / 1ps
module blake3_hash_engine #(
  parameter int STACK_DEPTH = 54
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [63:0] data,
  input  logic [3:0]  byte_count,
  input  logic        last,
  output logic        digest_valid,
  input  logic        digest_stall,
  output logic [63:0] digest_word,
  output logic        last_word
);

  localparam logic REG_OUTPUT_WORDS = 1'b0;

  logic [6:0]          output_words;
  logic                q_full;
  logic                q_push;
  blk3_pkg::blk3_cmd_t q_push_cmd;
  logic                q_pop;
  logic                q_valid;
  blk3_pkg::blk3_cmd_t q_head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_OUTPUT_WORDS) ? {25'd0, output_words} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_words <= 7'd4;
    end else if (psel && penable && pwrite && paddr[2] == REG_OUTPUT_WORDS) begin
      output_words <= pwdata[6:0];
    end
  end

  blk3_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .data       (data),
    .byte_count (byte_count),
    .last       (last),
    .q_full     (q_full),
    .push       (q_push),
    .push_cmd   (q_push_cmd)
  );

  blk3_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  blk3_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk          (clk),
    .rst          (rst),
    .output_words (output_words),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .pop          (q_pop),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest_word  (digest_word),
    .last_word    (last_word)
  );

endmodule
